>>> rtl/core/xsr_pkg.sv
`default_nettype none

package xsr_pkg;

    // Generator and mixing constants.
    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] XS_MULT      = 64'h2545_F491_4F6C_DD1D;
    localparam logic [63:0] MIX_MULT_A   = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MULT_B   = 64'h94D0_49BB_1331_11EB;
    localparam logic [31:0] FULL32       = 32'hFFFF_FFFF;

    // Operation codes carried on the action field.
    localparam logic [1:0] ACT_SEED    = 2'd0;
    localparam logic [1:0] ACT_RAW     = 2'd1;
    localparam logic [1:0] ACT_FRAC    = 2'd2;
    localparam logic [1:0] ACT_BOUNDED = 2'd3;

    // Width of the microprogram step counter.
    localparam int PC_W = 5;

    // Entry points and loop targets in the microprogram.
    localparam logic [PC_W-1:0] UA_SEED    = 5'd0;
    localparam logic [PC_W-1:0] UA_RAW     = 5'd7;
    localparam logic [PC_W-1:0] UA_FRAC    = 5'd12;
    localparam logic [PC_W-1:0] UA_BOUNDED = 5'd17;
    localparam logic [PC_W-1:0] UA_RETRY   = 5'd18;
    localparam logic [PC_W-1:0] UA_ZERO    = 5'd25;

    // Datapath operations, one per microinstruction.
    typedef enum logic [4:0] {
        OP_NOP,
        OP_SEED_ADD,
        OP_MIX30,
        OP_MIX27,
        OP_MIX31,
        OP_MUL_A,
        OP_MUL_B,
        OP_LOAD_STATE,
        OP_XS12,
        OP_XS25,
        OP_XS27,
        OP_MUL_X,
        OP_LIMIT,
        OP_MODV,
        OP_EMIT_RAW,
        OP_EMIT_FRAC,
        OP_EMIT_ZERO
    } t_op;

    // Sequencing: fall through, finish the program, or jump when the draw is too large.
    typedef enum logic [1:0] {
        SQ_NEXT,
        SQ_END,
        SQ_JGE
    } t_seq;

    typedef struct packed {
        t_op             op;
        t_seq            seq;
        logic [PC_W-1:0] target;
    } t_uword;

    // Start and finish strobes of a multi-cycle arithmetic unit.
    typedef struct packed {
        logic start;
    } t_unit_req;

    typedef struct packed {
        logic done;
    } t_unit_rsp;

    // Program entry for an accepted item.
    function automatic logic [PC_W-1:0] xsr_entry(input logic [1:0] action,
                                                  input logic       bound_zero);
        logic [PC_W-1:0] addr;
        unique case (action)
            ACT_SEED: addr = UA_SEED;
            ACT_RAW:  addr = UA_RAW;
            ACT_FRAC: addr = UA_FRAC;
            default:  addr = bound_zero ? UA_ZERO : UA_BOUNDED;
        endcase
        return addr;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/xorshift64star_prng_with_bounded_draw.sv
`default_nettype none

// xorshift64* generator with splitmix64 seeding, driven by a small microprogram.
// Each accepted item runs one program from a control store. A seed item gives no result;
// it mixes the seed with two 64-bit multiplies, each built from three 32x32 partial
// products. A raw or fraction draw runs three shift steps, the multiply and the step that
// loads the output register. A bounded draw computes the limit, repeats the draw while it
// is not below the limit, then takes the final remainder; the limit and the remainder each
// come from a one-bit-per-cycle divider of 32 steps. A bound of zero returns 0 from a
// single step. A result step waits while the output register still holds an
// untransferred result. A new item is taken in the cycle after the previous program ends,
// even while its result still waits in the output register.
module xorshift64star_prng_with_bounded_draw (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [63:0] i_seed_value,
    input  wire logic [31:0] i_bound,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [63:0] o_draw_value
);
    import xsr_pkg::*;

    logic            r_run;
    logic            r_wait;
    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic [63:0]     r_seed;
    logic [31:0]     r_n;
    logic [63:0]     r_acc;
    logic [63:0]     n_acc;
    logic [63:0]     r_state;
    logic [63:0]     n_state;
    logic [31:0]     r_limit;
    logic [31:0]     n_limit;
    logic [63:0]     r_out;
    logic [63:0]     n_out;
    logic            r_out_valid;
    t_uword          w_uw;
    logic            w_in_xfer;
    logic            w_is_mul;
    logic            w_is_div;
    logic            w_is_emit;
    logic            w_stall;
    logic            w_step;
    logic            w_emit;
    logic [63:0]     w_mul_a;
    logic [63:0]     w_mul_b;
    logic [63:0]     w_product;
    logic [31:0]     w_div_dvd;
    logic [31:0]     w_rem;
    t_unit_req       w_mul_req;
    t_unit_rsp       w_mul_rsp;
    t_unit_req       w_div_req;
    t_unit_rsp       w_div_rsp;

    xsr_urom u_urom (
        .i_pc   (r_pc),
        .o_word (w_uw)
    );

    // Classify the current microinstruction.
    assign w_is_mul  = (w_uw.op == OP_MUL_A) || (w_uw.op == OP_MUL_B)
                    || (w_uw.op == OP_MUL_X);
    assign w_is_div  = (w_uw.op == OP_LIMIT) || (w_uw.op == OP_MODV);
    assign w_is_emit = (w_uw.op == OP_EMIT_RAW) || (w_uw.op == OP_EMIT_FRAC)
                    || (w_uw.op == OP_EMIT_ZERO);

    // A step waits for its arithmetic unit, or for room in the output register.
    always_comb begin
        w_stall = 1'b0;
        if (w_is_mul) begin
            w_stall = !w_mul_rsp.done;
        end else if (w_is_div) begin
            w_stall = !w_div_rsp.done;
        end else if (w_is_emit) begin
            w_stall = r_out_valid && !i_out_ready;
        end
    end

    assign w_step    = r_run && !w_stall;
    assign w_emit    = w_step && w_is_emit;
    assign w_in_xfer = i_in_valid && o_in_ready;

    // Unit requests are issued once, on the first cycle of a waiting step.
    assign w_mul_req.start = r_run && w_is_mul && !r_wait;
    assign w_div_req.start = r_run && w_is_div && !r_wait;

    // Operand selection for the shared units.
    always_comb begin
        w_mul_a = r_acc;
        w_mul_b = XS_MULT;
        unique case (w_uw.op)
            OP_MUL_A: w_mul_b = MIX_MULT_A;
            OP_MUL_B: w_mul_b = MIX_MULT_B;
            OP_MUL_X: w_mul_a = r_state;
            default: ;
        endcase
    end

    assign w_div_dvd = (w_uw.op == OP_LIMIT) ? FULL32 : r_acc[63:32];

    xsr_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mul_req),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_rsp     (w_mul_rsp),
        .o_product (w_product)
    );

    xsr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .i_dividend (w_div_dvd),
        .i_divisor  (r_n),
        .o_rsp      (w_div_rsp),
        .o_rem      (w_rem)
    );

    // Datapath effect of the current step.
    always_comb begin
        n_acc   = r_acc;
        n_state = r_state;
        n_limit = r_limit;
        n_out   = r_out;
        unique case (w_uw.op)
            OP_SEED_ADD:   n_acc   = r_seed + GOLDEN_GAMMA;
            OP_MIX30:      n_acc   = r_acc ^ (r_acc >> 30);
            OP_MIX27:      n_acc   = r_acc ^ (r_acc >> 27);
            OP_MIX31:      n_acc   = r_acc ^ (r_acc >> 31);
            OP_MUL_A,
            OP_MUL_B,
            OP_MUL_X:      n_acc   = w_product;
            OP_LOAD_STATE: n_state = (r_acc == 64'd0) ? GOLDEN_GAMMA : r_acc;
            OP_XS12:       n_state = r_state ^ (r_state >> 12);
            OP_XS25:       n_state = r_state ^ (r_state << 25);
            OP_XS27:       n_state = r_state ^ (r_state >> 27);
            OP_LIMIT:      n_limit = FULL32 - w_rem;
            OP_MODV:       n_acc   = {32'd0, w_rem};
            OP_EMIT_RAW:   n_out   = r_acc;
            OP_EMIT_FRAC:  n_out   = {40'd0, r_acc[63:40]};
            OP_EMIT_ZERO:  n_out   = 64'd0;
            default: ;
        endcase
    end

    // Step counter: fall through, jump back on a rejected draw, or finish.
    always_comb begin
        n_pc = r_pc + 5'd1;
        if (w_uw.seq == SQ_JGE && r_acc[63:32] >= r_limit) begin
            n_pc = w_uw.target;
        end
    end

    // Sequencer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_wait <= 1'b0;
            r_pc   <= '0;
        end else begin
            if (w_mul_req.start || w_div_req.start) begin
                r_wait <= 1'b1;
            end else if (w_step) begin
                r_wait <= 1'b0;
            end
            if (w_in_xfer) begin
                r_run <= 1'b1;
                r_pc  <= xsr_entry(i_action, i_bound == 32'd0);
            end else if (w_step) begin
                if (w_uw.seq == SQ_END) begin
                    r_run <= 1'b0;
                end else begin
                    r_pc <= n_pc;
                end
            end
        end
    end

    // Generator state: reset to the golden gamma.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= GOLDEN_GAMMA;
        end else if (w_step) begin
            r_state <= n_state;
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_seed <= i_seed_value;
            r_n    <= i_bound;
        end
        if (w_step) begin
            r_acc   <= n_acc;
            r_limit <= n_limit;
        end
        if (w_emit) begin
            r_out <= n_out;
        end
    end

    // Output register: holds a result until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready   = !r_run;
    assign o_out_valid  = r_out_valid;
    assign o_draw_value = r_out;

    // A unit only finishes work that the sequencer is waiting for.
    a_mul_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_rsp.done |-> (r_wait && w_is_mul))
        else $error("multiplier finished with no step waiting");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_wait && w_is_div))
        else $error("divider finished with no step waiting");

    // No unit is pending once the sequencer is idle.
    a_idle_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run |-> !r_wait)
        else $error("unit request pending while idle");

    // The generator never falls into the all-zero state.
    a_state_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != 64'd0)
        else $error("generator state became zero");

    // A result never overwrites one that has not been transferred.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_out_valid) |-> i_out_ready)
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire

>>> rtl/core/xsr_urom.sv
`default_nettype none

module xsr_urom (
    input  wire logic [xsr_pkg::PC_W-1:0] i_pc,
    output xsr_pkg::t_uword               o_word
);
    import xsr_pkg::*;

    // Control store: one word per step of each operation.
    always_comb begin
        o_word = '{op: OP_NOP, seq: SQ_END, target: '0};
        unique case (i_pc)
            // Seed: splitmix64 mix of the seed, then load the state.
            5'd0:  o_word = '{op: OP_SEED_ADD,   seq: SQ_NEXT, target: '0};
            5'd1:  o_word = '{op: OP_MIX30,      seq: SQ_NEXT, target: '0};
            5'd2:  o_word = '{op: OP_MUL_A,      seq: SQ_NEXT, target: '0};
            5'd3:  o_word = '{op: OP_MIX27,      seq: SQ_NEXT, target: '0};
            5'd4:  o_word = '{op: OP_MUL_B,      seq: SQ_NEXT, target: '0};
            5'd5:  o_word = '{op: OP_MIX31,      seq: SQ_NEXT, target: '0};
            5'd6:  o_word = '{op: OP_LOAD_STATE, seq: SQ_END,  target: '0};
            // Raw draw.
            5'd7:  o_word = '{op: OP_XS12,       seq: SQ_NEXT, target: '0};
            5'd8:  o_word = '{op: OP_XS25,       seq: SQ_NEXT, target: '0};
            5'd9:  o_word = '{op: OP_XS27,       seq: SQ_NEXT, target: '0};
            5'd10: o_word = '{op: OP_MUL_X,      seq: SQ_NEXT, target: '0};
            5'd11: o_word = '{op: OP_EMIT_RAW,   seq: SQ_END,  target: '0};
            // Fraction draw.
            5'd12: o_word = '{op: OP_XS12,       seq: SQ_NEXT, target: '0};
            5'd13: o_word = '{op: OP_XS25,       seq: SQ_NEXT, target: '0};
            5'd14: o_word = '{op: OP_XS27,       seq: SQ_NEXT, target: '0};
            5'd15: o_word = '{op: OP_MUL_X,      seq: SQ_NEXT, target: '0};
            5'd16: o_word = '{op: OP_EMIT_FRAC,  seq: SQ_END,  target: '0};
            // Bounded draw with rejection loop.
            5'd17: o_word = '{op: OP_LIMIT,      seq: SQ_NEXT, target: '0};
            5'd18: o_word = '{op: OP_XS12,       seq: SQ_NEXT, target: '0};
            5'd19: o_word = '{op: OP_XS25,       seq: SQ_NEXT, target: '0};
            5'd20: o_word = '{op: OP_XS27,       seq: SQ_NEXT, target: '0};
            5'd21: o_word = '{op: OP_MUL_X,      seq: SQ_NEXT, target: '0};
            5'd22: o_word = '{op: OP_NOP,        seq: SQ_JGE,  target: UA_RETRY};
            5'd23: o_word = '{op: OP_MODV,       seq: SQ_NEXT, target: '0};
            5'd24: o_word = '{op: OP_EMIT_RAW,   seq: SQ_END,  target: '0};
            // Bound of zero.
            5'd25: o_word = '{op: OP_EMIT_ZERO,  seq: SQ_END,  target: '0};
            default: o_word = '{op: OP_NOP, seq: SQ_END, target: '0};
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/xsr_mul.sv
`default_nettype none

module xsr_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire xsr_pkg::t_unit_req i_req,
    input  wire logic [63:0]       i_a,
    input  wire logic [63:0]       i_b,
    output xsr_pkg::t_unit_rsp     o_rsp,
    output logic      [63:0]       o_product
);
    import xsr_pkg::*;

    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_prod;
    logic [63:0] r_res;
    logic [1:0]  r_phase;
    logic        r_busy;
    logic        r_done;
    logic [31:0] w_opa;
    logic [31:0] w_opb;

    // One 32x32 partial product per cycle: low*low, low*high, high*low.
    assign w_opa = (r_phase == 2'd2) ? r_a[63:32] : r_a[31:0];
    assign w_opb = (r_phase == 2'd1) ? r_b[63:32] : r_b[31:0];

    // Control: step through the phases after start, then raise the done strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_phase <= 2'd0;
            end else if (r_busy) begin
                r_phase <= r_phase + 2'd1;
                if (r_phase == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand capture, registered product and accumulation of the upper word.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        r_prod <= {32'd0, w_opa} * {32'd0, w_opb};
        if (r_busy) begin
            unique case (r_phase)
                2'd0: ;
                2'd1: r_res <= r_prod;
                default: r_res[63:32] <= r_res[63:32] + r_prod[31:0];
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_product  = r_res;

endmodule

`default_nettype wire

>>> rtl/core/xsr_div.sv
`default_nettype none

module xsr_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire xsr_pkg::t_unit_req i_req,
    input  wire logic [31:0]   i_dividend,
    input  wire logic [31:0]   i_divisor,
    output xsr_pkg::t_unit_rsp o_rsp,
    output logic      [31:0]   o_rem
);
    import xsr_pkg::*;

    logic [31:0] r_dvd;
    logic [31:0] r_d;
    logic [31:0] r_rem;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_trial;
    logic [32:0] w_diff;
    logic [31:0] n_rem;

    // Restoring step: bring in one dividend bit, subtract the divisor if it fits.
    assign w_trial = {r_rem, r_dvd[31]};
    assign w_diff  = w_trial - {1'b0, r_d};
    assign n_rem   = w_diff[32] ? w_trial[31:0] : w_diff[31:0];

    // Control: 32 iterations, then a done strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rem      = r_rem;

endmodule

`default_nettype wire
